>>> hw/rtl/lclt_pkg.sv
package lclt_pkg;

	localparam int LINE_CAPACITY_DEF = 64;
	localparam logic [4:0] MAX_ARGS_RESET = 5'd8;
	localparam logic [4:0] ARG_LIMIT = 5'd16;
	localparam logic [5:0] RESULT_LIMIT = 6'd63;
	localparam int Q_DEPTH = 2;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_TOO_MANY = 2'd2
	} lclt_status_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_APPEND = 2'd1,
		OP_ERASE = 2'd2,
		OP_END = 2'd3
	} lclt_op_t;

	typedef struct packed {
		lclt_op_t op;
		logic [7:0] ch;
	} lclt_cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CNT_RD,
		B_CNT_CHK,
		B_DECIDE,
		B_EMIT_RD,
		B_EMIT_CHK,
		B_SUM
	} lclt_state_t;

endpackage

>>> hw/rtl/lclt_front.sv
module lclt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	input  logic              q_full,
	output logic              push,
	output lclt_pkg::lclt_cmd_t push_cmd
);
	import lclt_pkg::*;

	logic swallow_q;
	logic accept;
	logic swallow_hit;
	logic [7:0] ch;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign swallow_hit = swallow_q && (rx_byte == CH_LF);
	assign ch = (rx_byte == CH_TAB) ? CH_SPACE : rx_byte;

	always_comb begin
		push_cmd.ch = ch;
		if (rx_byte == CH_LF || rx_byte == CH_CR) begin
			push_cmd.op = OP_END;
		end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
			push_cmd.op = OP_ERASE;
		end else if (ch < CH_SPACE) begin
			push_cmd.op = OP_NONE;
		end else begin
			push_cmd.op = OP_APPEND;
		end
	end

	assign push = accept && !swallow_hit && (push_cmd.op != OP_NONE);

	// an LF right after a CR is dropped; any accepted byte but a CR clears the mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swallow_q <= 1'b0;
		end else if (accept) begin
			swallow_q <= (rx_byte == CH_CR);
		end
	end

endmodule

>>> hw/rtl/lclt_queue.sv
module lclt_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lclt_pkg::lclt_cmd_t push_cmd,
	input  logic                pop,
	output lclt_pkg::lclt_cmd_t pop_cmd,
	output logic                full,
	output logic                empty
);
	import lclt_pkg::*;

	localparam int AW = $clog2(Q_DEPTH);

	lclt_cmd_t entries_q [Q_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_cmd = entries_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_cmd;
		end
	end

endmodule

>>> hw/rtl/lclt_back.sv
module lclt_back #(
	parameter int LINE_CAPACITY = lclt_pkg::LINE_CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          max_args,
	input  logic                q_empty,
	input  lclt_pkg::lclt_cmd_t q_cmd,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output logic [7:0]          char_out,
	output logic [3:0]          arg_index,
	output logic                token_end,
	output logic [1:0]          status,
	output logic [4:0]          arg_count,
	output logic                last
);
	import lclt_pkg::*;

	localparam int LW = $clog2(LINE_CAPACITY);
	localparam int CMPW = (LW > 5) ? LW : 5;
	localparam logic [LW-1:0] LEN_MAX = LW'(LINE_CAPACITY - 1);

	logic [7:0] mem [LINE_CAPACITY];

	lclt_state_t state_q, state_d;
	logic [LW-1:0] len_q;
	logic ovf_q;
	logic [LW-1:0] i_q;
	logic [7:0] rdata_q;
	logic [LW-1:0] cnt_q;
	logic prev_sp_q;
	lclt_status_t status_q;
	logic [4:0] arg_q;
	logic in_tok_q;
	logic pend_q;
	logic [7:0] pend_ch_q;
	logic [3:0] pend_arg_q;
	logic [5:0] n_q;

	logic out_valid_q;
	logic kind_q;
	logic [7:0] char_q;
	logic [3:0] arg_idx_q;
	logic tend_q;
	logic [1:0] status_out_q;
	logic [4:0] count_out_q;
	logic last_q;

	logic at_end;
	logic out_free;
	logic [4:0] lim;
	logic [CMPW-1:0] cnt_ext;
	logic [CMPW-1:0] lim_ext;
	logic emit_want;
	logic emit_stall;
	logic rd_en;
	logic emit_go;
	logic sum_go;
	logic chk_step;
	logic rd_space;
	logic full_line;

	assign at_end = (i_q == len_q);
	assign out_free = !out_valid_q || out_ready;
	assign lim = (max_args > ARG_LIMIT) ? ARG_LIMIT : max_args;
	assign cnt_ext = CMPW'(cnt_q);
	assign lim_ext = CMPW'(lim);
	assign emit_want = pend_q && (n_q != RESULT_LIMIT);
	assign emit_stall = emit_want && !out_free;
	assign rd_space = (rdata_q == CH_SPACE);
	assign full_line = (len_q == LEN_MAX);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty && q_cmd.op == OP_END && len_q != '0 && !ovf_q) begin
					state_d = B_CNT_RD;
				end
			end
			B_CNT_RD: state_d = at_end ? B_DECIDE : B_CNT_CHK;
			B_CNT_CHK: state_d = B_CNT_RD;
			B_DECIDE: begin
				if (lim == '0 || cnt_q == '0 || cnt_ext > lim_ext) begin
					state_d = B_SUM;
				end else begin
					state_d = B_EMIT_RD;
				end
			end
			B_EMIT_RD: state_d = B_EMIT_CHK;
			B_EMIT_CHK: begin
				if (!emit_stall) begin
					state_d = at_end ? B_SUM : B_EMIT_RD;
				end
			end
			B_SUM: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == B_IDLE) && !q_empty;
		rd_en = (state_q == B_CNT_RD || state_q == B_EMIT_RD) && !at_end;
		emit_go = (state_q == B_EMIT_CHK) && emit_want && out_free;
		sum_go = (state_q == B_SUM) && out_free;
		chk_step = (state_q == B_EMIT_CHK) && !emit_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			len_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				case (q_cmd.op)
					OP_APPEND: begin
						if (full_line) begin
							ovf_q <= 1'b1;
						end else begin
							len_q <= len_q + 1'b1;
						end
					end
					OP_ERASE: begin
						if (!ovf_q && len_q != '0) begin
							len_q <= len_q - 1'b1;
						end
					end
					OP_END: begin
						if (len_q == '0 || ovf_q) begin
							len_q <= '0;
							ovf_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (sum_go) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end
			if (emit_go || sum_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_cmd.op == OP_APPEND && !full_line) begin
			mem[len_q] <= q_cmd.ch;
		end
		if (rd_en) begin
			rdata_q <= mem[i_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			i_q <= '0;
			cnt_q <= '0;
			prev_sp_q <= 1'b1;
		end
		if (state_q == B_CNT_CHK) begin
			if (!rd_space && prev_sp_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
			prev_sp_q <= rd_space;
			i_q <= i_q + 1'b1;
		end
		if (state_q == B_DECIDE) begin
			if (lim == '0 || cnt_q == '0) begin
				status_q <= ST_EMPTY;
			end else if (cnt_ext > lim_ext) begin
				status_q <= ST_TOO_MANY;
			end else begin
				status_q <= ST_OK;
			end
			i_q <= '0;
			arg_q <= '0;
			in_tok_q <= 1'b0;
			pend_q <= 1'b0;
			n_q <= '0;
		end
		if (emit_go) begin
			kind_q <= 1'b0;
			char_q <= pend_ch_q;
			arg_idx_q <= pend_arg_q;
			tend_q <= at_end || rd_space;
			status_out_q <= ST_OK;
			count_out_q <= '0;
			last_q <= 1'b0;
			n_q <= n_q + 1'b1;
		end
		// pending char waits one read so its end-of-token mark is known
		if (chk_step && !at_end) begin
			if (rd_space) begin
				if (in_tok_q) begin
					arg_q <= arg_q + 1'b1;
				end
				in_tok_q <= 1'b0;
				pend_q <= 1'b0;
			end else begin
				in_tok_q <= 1'b1;
				pend_q <= 1'b1;
				pend_ch_q <= rdata_q;
				pend_arg_q <= arg_q[3:0];
			end
			i_q <= i_q + 1'b1;
		end
		if (sum_go) begin
			kind_q <= 1'b1;
			char_q <= '0;
			arg_idx_q <= '0;
			tend_q <= 1'b0;
			status_out_q <= status_q;
			count_out_q <= (status_q == ST_OK) ? cnt_ext[4:0] : 5'd0;
			last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign char_out = char_q;
	assign arg_index = arg_idx_q;
	assign token_end = tend_q;
	assign status = status_out_q;
	assign arg_count = count_out_q;
	assign last = last_q;

endmodule

>>> hw/rtl/console_line_assembler_tokenizer.sv
// channel   | signals                          | accepted when
// ----------+----------------------------------+---------------------------
// rx in     | in_valid, in_ready, rx_byte      | in_valid && in_ready
// result    | out_valid, out_ready, kind..last | out_valid && out_ready
// config    | cfg_we, cfg_wdata (max_args)     | cfg_we
//
// A byte is pushed into the two-entry command queue, which registers it; edits
// retire one by one while the back end is idle. Line end walks the store twice
// through the one registered read port: once to count tokens, once to emit them.
// Reset clears the line state and sets max_args to 8. Either side may stall:
// the queue absorbs bytes while a line is split, and results hold until taken.
module console_line_assembler_tokenizer #(
	parameter int LINE_CAPACITY = lclt_pkg::LINE_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] char_out,
	output logic [3:0] arg_index,
	output logic       token_end,
	output logic [1:0] status,
	output logic [4:0] arg_count,
	output logic       last,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);
	import lclt_pkg::*;

	logic [4:0] max_args_q;
	logic push;
	lclt_cmd_t push_cmd;
	logic pop;
	lclt_cmd_t pop_cmd;
	logic q_full;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= MAX_ARGS_RESET;
		end else if (cfg_we) begin
			max_args_q <= cfg_wdata;
		end
	end

	lclt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lclt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	lclt_back #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_args  (max_args_q),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.char_out  (char_out),
		.arg_index (arg_index),
		.token_end (token_end),
		.status    (status),
		.arg_count (arg_count),
		.last      (last)
	);

`ifndef SYNTHESIS
	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == kind))
		else $error("last flag disagrees with result kind");

	a_token_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |-> (status == ST_OK && arg_count == 5'd0))
		else $error("token result carries summary fields");

	a_count_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind && status != ST_OK) |-> (arg_count == 5'd0))
		else $error("nonzero arg count on failed line");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("command pushed into full queue");
`endif

endmodule

>>> tb/tb_top.sv
module tb_top;
	import lclt_pkg::*;

	localparam int SETTLE_CYCLES = 320;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic         kind;
		logic [7:0]   ch;
		logic [3:0]   arg;
		logic         tend;
		lclt_status_t st;
		logic [4:0]   cnt;
		logic         fin;
	} tok_rec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       kind;
	logic [7:0] char_out;
	logic [3:0] arg_index;
	logic       token_end;
	logic [1:0] status;
	logic [4:0] arg_count;
	logic       last;
	logic       cfg_we = 1'b0;
	logic [4:0] cfg_wdata = 5'd0;
	logic       hold_off = 1'b0;

	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int mismatches = 0;
	int bytes_sent = 0;

	// predicted line state
	logic [7:0]  pl_store [LINE_CAPACITY_DEF];
	int unsigned pl_len = 0;
	bit          pl_ovf = 1'b0;
	bit          pl_swallow = 1'b0;
	bit          pl_taken = 1'b0;
	logic [4:0]  pl_max_args = MAX_ARGS_RESET;

	tok_rec_t tok_due[$];

	console_line_assembler_tokenizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.char_out  (char_out),
		.arg_index (arg_index),
		.token_end (token_end),
		.status    (status),
		.arg_count (arg_count),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb_top failed");
		$finish;
	end

	task automatic push_summary(input lclt_status_t st, input logic [4:0] cnt);
		tok_rec_t r;
		r.kind = 1'b1;
		r.ch = 8'h00;
		r.arg = 4'd0;
		r.tend = 1'b0;
		r.st = st;
		r.cnt = cnt;
		r.fin = 1'b1;
		tok_due.push_back(r);
	endtask

	task automatic split_into_tokens();
		int unsigned limit, count, arg_no, n_chars, i;
		bit in_tok;
		tok_rec_t r;
		limit = (pl_max_args > ARG_LIMIT) ? ARG_LIMIT : pl_max_args;
		count = 0;
		for (i = 0; i < pl_len; i++) begin
			if (pl_store[i] != CH_SPACE && (i == 0 || pl_store[i - 1] == CH_SPACE))
				count++;
		end
		if (limit == 0 || count == 0) begin
			push_summary(ST_EMPTY, 5'd0);
			return;
		end
		if (count > limit) begin
			push_summary(ST_TOO_MANY, 5'd0);
			return;
		end
		arg_no = 0;
		in_tok = 1'b0;
		n_chars = 0;
		for (i = 0; i < pl_len; i++) begin
			if (pl_store[i] == CH_SPACE) begin
				if (in_tok)
					arg_no++;
				in_tok = 1'b0;
			end else begin
				in_tok = 1'b1;
				if (n_chars < RESULT_LIMIT) begin
					r.kind = 1'b0;
					r.ch = pl_store[i];
					r.arg = arg_no[3:0];
					r.tend = (i + 1 == pl_len) || (pl_store[i + 1] == CH_SPACE);
					r.st = ST_OK;
					r.cnt = 5'd0;
					r.fin = 1'b0;
					tok_due.push_back(r);
					n_chars++;
				end
			end
		end
		push_summary(ST_OK, count[4:0]);
	endtask

	task automatic assemble_byte(input logic [7:0] b);
		logic [7:0] c;
		if (pl_swallow) begin
			pl_swallow = 1'b0;
			if (b == CH_LF)
				return;
		end
		if (pl_taken) begin
			pl_len = 0;
			pl_ovf = 1'b0;
			pl_taken = 1'b0;
		end
		if (b == CH_LF || b == CH_CR) begin
			if (pl_len > 0 && !pl_ovf) begin
				pl_taken = 1'b1;
				pl_swallow = (b == CH_CR);
				split_into_tokens();
				return;
			end
			pl_len = 0;
			pl_ovf = 1'b0;
			pl_taken = 1'b0;
			pl_swallow = (b == CH_CR);
			return;
		end
		if (b == CH_BS || b == CH_DEL) begin
			if (!pl_ovf && pl_len > 0)
				pl_len--;
			return;
		end
		c = (b == CH_TAB) ? CH_SPACE : b;
		if (c < CH_SPACE)
			return;
		if (pl_len + 1 >= LINE_CAPACITY_DEF) begin
			pl_ovf = 1'b1;
			return;
		end
		pl_store[pl_len] = c;
		pl_len++;
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		tok_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tok_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, kind %0d char %0h",
					kind, char_out));
			end else begin
				want = tok_due.pop_front();
				check_field("kind", 8'(kind), 8'(want.kind));
				check_field("char_out", char_out, want.ch);
				check_field("arg_index", 8'(arg_index), 8'(want.arg));
				check_field("token_end", 8'(token_end), 8'(want.tend));
				check_field("status", 8'(status), 8'(want.st));
				check_field("arg_count", 8'(arg_count), 8'(want.cnt));
				check_field("last", 8'(last), 8'(want.fin));
			end
		end
	end

	always @(posedge clk)
		out_ready <= !hold_off && ($urandom_range(99) >= out_stall_pct);

	// call at a clock edge; valid stays up after the request so back-to-back bytes flow
	task automatic send_byte(input logic [7:0] b);
		while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		assemble_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_line_idle();
		in_valid <= 1'b0;
		while (tok_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_args(input logic [4:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		pl_max_args = v;
	endtask

	task automatic test_line_editing();
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_text("ab");
		send_byte(CH_TAB);
		send_text("c");
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_text("xy");
		send_byte(CH_BS);
		send_byte(CH_DEL);
		send_byte(8'h00);
		send_byte(8'h1B);
		send_text("z");
		send_byte(CH_LF);
		// erase on an empty line, then a line of blanks only
		send_byte(CH_BS);
		send_text(" ");
		send_byte(CH_TAB);
		send_byte(CH_CR);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_LF);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_text("~! x");
		send_byte(CH_LF);
		wait_line_idle();
	endtask

	task automatic test_arg_limit();
		write_max_args(5'd0);
		send_text("a b");
		send_byte(CH_CR);
		wait_line_idle();
		write_max_args(5'd1);
		send_text("a");
		send_byte(CH_CR);
		send_text(" a b ");
		send_byte(CH_LF);
		wait_line_idle();
		write_max_args(5'd31);
		send_text("a b c d e f g h i j k l m n o pp");
		send_byte(CH_CR);
		send_text("a b c d e f g h i j k l m n o p q");
		send_byte(CH_CR);
		wait_line_idle();
		write_max_args(MAX_ARGS_RESET);
	endtask

	task automatic test_capacity();
		int k;
		// fill the store to its last free slot
		for (k = 0; k < LINE_CAPACITY_DEF - 1; k++)
			send_byte(8'(8'h41 + k % 26));
		// erase and refill at the full mark, then one byte too many
		send_byte(CH_BS);
		send_text("q");
		send_text("r");
		// overflowed: erase no longer edits, line is dropped
		send_byte(CH_BS);
		send_byte(CH_LF);
		send_text("k");
		send_byte(CH_CR);
		wait_line_idle();
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		// receiver holds off while requests keep coming, so the input stalls
		send_text("ab cd ef");
		send_byte(CH_CR);
		send_text("gh ij");
		send_byte(CH_LF);
		wait_line_idle();
	endtask

	task automatic test_random_lines(input int idle_pct, input int stall_pct, input int n_bytes);
		int stop_at, len, k, pick;
		logic [7:0] b;
		wait_line_idle();
		in_idle_pct = idle_pct;
		out_stall_pct = stall_pct;
		if ($urandom_range(3) == 0)
			write_max_args(5'($urandom_range(31)));
		else
			write_max_args(5'($urandom_range(16, 1)));
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			len = ($urandom_range(11) == 0) ? $urandom_range(70, 50) : $urandom_range(16);
			for (k = 0; k < len; k++) begin
				pick = $urandom_range(99);
				if (pick < 55)
					b = 8'($urandom_range(8'h7E, 8'h21));
				else if (pick < 72)
					b = CH_SPACE;
				else if (pick < 77)
					b = CH_TAB;
				else if (pick < 82)
					b = $urandom_range(1) ? CH_BS : CH_DEL;
				else if (pick < 88)
					b = 8'($urandom_range(8'hFF, 8'h80));
				else
					b = 8'($urandom_range(255));
				send_byte(b);
			end
			pick = $urandom_range(9);
			if (pick < 4) begin
				send_byte(CH_CR);
			end else if (pick < 6) begin
				send_byte(CH_LF);
			end else if (pick < 9) begin
				send_byte(CH_CR);
				send_byte(CH_LF);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_line_editing();
		test_arg_limit();
		test_capacity();
		test_backpressure();
		test_random_lines(0, 0, 6);
		test_random_lines(54, 0, 6);
		test_random_lines(0, 54, 6);
		test_random_lines(36, 36, 6);
		wait_line_idle();
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

>>> console_line_assembler_tokenizer.f
hw/rtl/lclt_pkg.sv
hw/rtl/lclt_front.sv
hw/rtl/lclt_queue.sv
hw/rtl/lclt_back.sv
hw/rtl/console_line_assembler_tokenizer.sv
tb/tb_top.sv
